// ----- sv/aging_id_table_top_assert.svh -----
// Assertion macros for the aging identifier table.
// Relies on i_clk and i_rst_n in the scope where a macro is used.
`ifndef AGING_ID_TABLE_TOP_ASSERT_SVH
`define AGING_ID_TABLE_TOP_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define AIT_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define AIT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- sv/ait_pkg.sv -----
// Shared constants, types and helpers for the aging identifier table.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package ait_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int COUNT_BITS  = 24;
    localparam int ID_W        = 16;
    localparam int CFG_W       = 24;
    localparam int ENTRY_W     = 7;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH + 1);

    localparam logic [CFG_W-1:0] RELOAD_RESET = CFG_W'(600000);

    localparam logic CMD_PUSH   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]       ident;
        logic [COUNT_BITS-1:0] countdown;
    } t_slot;

    // Fit the reload register to the countdown width (truncate or zero-fill).
    function automatic logic [COUNT_BITS-1:0] to_count(input logic [CFG_W-1:0] v);
        logic [COUNT_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < COUNT_BITS; i++) begin
            if (i < CFG_W) begin
                r[i] = v[i];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/ait_item_if.sv -----
// Input item channel: command, identifier and grant flag with valid/ready.
// Depends on ait_pkg for field widths.
`default_nettype none

interface ait_item_if;
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [ait_pkg::ID_W-1:0] ident;
    logic                    has_grant;

    modport source (output valid, output command, output ident, output has_grant,
                    input ready);
    modport sink   (input valid, input command, input ident, input has_grant,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/ait_res_if.sv -----
// Result item channel: lookup flags and entry count with valid/ready.
// Depends on ait_pkg for field widths.
`default_nettype none

interface ait_res_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic                        expired;
    logic                        table_full;
    logic [ait_pkg::ENTRY_W-1:0] entry_count;

    modport source (output valid, output found, output expired, output table_full,
                    output entry_count, input ready);
    modport sink   (input valid, input found, input expired, input table_full,
                    input entry_count, output ready);
endinterface

`default_nettype wire

// ----- sv/ait_cfg_if.sv -----
// Configuration write channel carrying the reload count with valid/ready.
// Depends on ait_pkg for the register width.
`default_nettype none

interface ait_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [ait_pkg::CFG_W-1:0] reload_count;

    modport source (output valid, output reload_count, input ready);
    modport sink   (input valid, input reload_count, output ready);
endinterface

`default_nettype wire

// ----- sv/aging_id_table_top.sv -----
// Aging identifier table: top level with slot memory, scan and apply logic.
// Depends on ait_pkg, the three channel interfaces and the assertion header.
//
// The block keeps up to TABLE_DEPTH identifiers, each with a countdown, in one
// synchronous slot memory; valid bits and the entry count sit in flip-flops.
// Each item scans every slot, one memory read per cycle, to find the
// identifier and the lowest free slot, then applies the push or update with
// one memory write and loads the result register. The result follows the
// slot reads through the single memory read port, the compare of the last
// slot and the apply step. The input is ready again once the apply returns
// the block to idle, so a new item is taken only after the last one has
// been applied. One item is in work at a time, and the next is accepted
// while the result waits; a result that is not taken holds the following
// item in its apply step. The configuration channel is ready whenever reset
// is released.
`default_nettype none

module aging_id_table_top (
    input  wire             i_clk,
    input  wire             i_rst_n,
    ait_item_if.sink        i_item,
    ait_res_if.source       o_res,
    ait_cfg_if.sink         i_cfg
);

    `include "aging_id_table_top_assert.svh"

    localparam int DEPTH = ait_pkg::TABLE_DEPTH;
    localparam int IW    = ait_pkg::IDX_W;
    localparam int AW    = ait_pkg::ADDR_W;
    localparam int CW    = ait_pkg::COUNT_BITS;
    localparam int EW    = ait_pkg::ENTRY_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_APPLY} t_state;

    t_state                     r_state;
    logic                       r_cmd;
    logic [ait_pkg::ID_W-1:0]   r_ident;
    logic                       r_grant;
    logic [ait_pkg::CFG_W-1:0]  r_reload;
    logic [AW-1:0]              r_addr;
    logic                       r_cmp_vld;
    logic [IW-1:0]              r_cmp_idx;
    logic                       r_hit;
    logic [IW-1:0]              r_hit_idx;
    logic [CW-1:0]              r_hit_cnt;
    logic                       r_free;
    logic [IW-1:0]              r_free_idx;
    logic [DEPTH-1:0]           r_valid;
    logic [EW-1:0]              r_total;
    logic                       r_out_valid;
    logic                       r_out_found;
    logic                       r_out_expired;
    logic                       r_out_full;
    logic [EW-1:0]              r_out_count;

    ait_pkg::t_slot             mem [DEPTH];
    ait_pkg::t_slot             r_rd_data;

    logic                       w_issue;
    logic                       w_last;
    logic                       w_out_free;
    logic                       w_apply;
    logic                       w_match;
    logic [CW-1:0]              w_reload;
    logic [CW-1:0]              w_dec;
    logic                       w_found;
    logic                       w_expired;
    logic                       w_full;
    logic                       w_we;
    logic                       w_mem_we;
    logic [IW-1:0]              w_waddr;
    ait_pkg::t_slot             w_wdata;
    logic                       w_set;
    logic                       w_clr;
    logic [EW-1:0]              n_total;

    // Handshake and output drive
    assign i_item.ready      = i_rst_n && (r_state == ST_IDLE);
    assign i_cfg.ready       = i_rst_n;
    assign o_res.valid       = r_out_valid;
    assign o_res.found       = r_out_found;
    assign o_res.expired     = r_out_expired;
    assign o_res.table_full  = r_out_full;
    assign o_res.entry_count = r_out_count;

    // Scan control: issue one slot read per cycle, compare the read data in the next cycle
    assign w_issue    = (r_state == ST_SCAN) && (r_addr != AW'(DEPTH));
    assign w_last     = r_cmp_vld && (r_cmp_idx == IW'(DEPTH - 1));
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_apply    = (r_state == ST_APPLY) && w_out_free;
    assign w_match    = r_cmp_vld && r_valid[r_cmp_idx] && (r_rd_data.ident == r_ident);

    // Countdown arithmetic
    assign w_reload = ait_pkg::to_count(r_reload);
    assign w_dec    = (r_hit_cnt != '0) ? (r_hit_cnt - CW'(1)) : '0;

    // Decide the effect of the item once the scan is complete
    always_comb begin
        w_found   = 1'b0;
        w_expired = 1'b0;
        w_full    = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_hit_idx;
        w_wdata   = '{ident: r_ident, countdown: w_reload};
        w_set     = 1'b0;
        w_clr     = 1'b0;
        n_total   = r_total;
        if (r_cmd == ait_pkg::CMD_PUSH) begin
            if (r_hit) begin
                w_found = 1'b1;
                w_we    = 1'b1;
            end else if (r_free) begin
                w_we    = 1'b1;
                w_waddr = r_free_idx;
                w_set   = 1'b1;
                n_total = r_total + EW'(1);
            end else begin
                w_full = 1'b1;
            end
        end else if (r_hit) begin
            w_found = 1'b1;
            w_we    = 1'b1;
            if (!r_grant) begin
                w_wdata.countdown = w_dec;
                if (w_dec == '0) begin
                    w_clr     = 1'b1;
                    w_expired = 1'b1;
                    n_total   = r_total - EW'(1);
                end
            end
        end
    end

    assign w_mem_we = w_apply && w_we;

    // Slot memory write port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_waddr] <= w_wdata;
        end
    end

    // Slot memory read port, registered data
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_data <= mem[r_addr[IW-1:0]];
        end
    end

    // State, scan tracking, valid bits and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_reload    <= ait_pkg::RELOAD_RESET;
            r_addr      <= '0;
            r_cmp_vld   <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_valid     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // take configuration writes
            if (i_cfg.valid && i_cfg.ready) begin
                r_reload <= i_cfg.reload_count;
            end

            // drop the result once taken
            if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            // advance the scan pipeline
            r_cmp_vld <= w_issue;
            r_cmp_idx <= r_addr[IW-1:0];
            if (w_issue) begin
                r_addr <= r_addr + AW'(1);
            end

            // record the matching slot and the lowest free slot
            if (w_match && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_cmp_idx;
                r_hit_cnt <= r_rd_data.countdown;
            end
            if (r_cmp_vld && !r_valid[r_cmp_idx] && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_item.valid) begin
                        r_cmd   <= i_item.command;
                        r_ident <= i_item.ident;
                        r_grant <= i_item.has_grant;
                        r_addr  <= '0;
                        r_hit   <= 1'b0;
                        r_free  <= 1'b0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_last) begin
                        r_state <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    if (w_out_free) begin
                        if (w_set) begin
                            r_valid[r_free_idx] <= 1'b1;
                        end
                        if (w_clr) begin
                            r_valid[r_hit_idx] <= 1'b0;
                        end
                        r_total       <= n_total;
                        r_out_valid   <= 1'b1;
                        r_out_found   <= w_found;
                        r_out_expired <= w_expired;
                        r_out_full    <= w_full;
                        r_out_count   <= n_total;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Checks on the table logic
    `AIT_ASSERT_SAME(a_expired_needs_found, r_out_valid && r_out_expired, r_out_found,
        "expired reported without a found entry")
    `AIT_ASSERT_SAME(a_full_is_alone, r_out_valid && r_out_full,
        !r_out_found && !r_out_expired,
        "table full reported together with a hit or an expiry")
    `AIT_ASSERT_SAME(a_hit_is_valid, (r_state == ST_APPLY) && r_hit, r_valid[r_hit_idx],
        "recorded hit slot is not valid")
    `AIT_ASSERT_SAME(a_write_in_apply, w_mem_we, (r_state == ST_APPLY) && w_out_free,
        "slot memory written outside the apply step")
    `AIT_ASSERT_NEXT(a_accept_starts_scan, i_item.valid && i_item.ready,
        (r_state == ST_SCAN) && (r_addr == '0) && !r_hit && !r_free,
        "accepted item did not start a clean scan")

endmodule

`default_nettype wire
